>>> src/rst_tbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rst_tbl_pkg
// Shared types, codes and constants of the record slot table.
// ----------------------------------------------------------------------------
package rst_tbl_pkg;

  localparam int SLOTS_DEF  = 32;
  localparam int RESULT_CAP = 32;

  typedef enum logic [2:0] {
    MODE_INSERT   = 3'd0,
    MODE_SEARCH   = 3'd1,
    MODE_DEL_NAME = 3'd2,
    MODE_DEL_POS  = 3'd3,
    MODE_PRINT    = 3'd4,
    MODE_MAX      = 3'd5,
    MODE_SORT     = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_RECORD    = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DONE      = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] health;
    logic [15:0] mana;
    logic [15:0] speed;
    logic [9:0]  reach;
    logic [2:0]  position;
  } rec_t;

  typedef struct packed {
    logic    last;
    status_t status;
    logic [4:0] slot;
    rec_t    rec;
  } out_t;

  typedef struct packed {
    logic load;
    logic ins_step;
    logic eval;
    logic pass2;
    logic finish;
    logic srt_ld;
    logic srt_ev;
    logic srt_end;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  at_end;
    logic  cap_hit;
    logic  ins_done;
    logic  out_free;
    logic  srt_last;
    logic  srt_pass_last;
    logic  few;
    logic  pass2;
  } stat_t;

endpackage

>>> src/rst_tbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rst_tbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rst_tbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/rst_tbl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rst_tbl_ctrl
// Command sequencer: scans, listing passes and the bubble sort passes.
// ----------------------------------------------------------------------------
module rst_tbl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  rst_tbl_pkg::stat_t st,
  output rst_tbl_pkg::cmd_t  cmd
);
  import rst_tbl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_INS  = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_EV   = 10'b0000001000,
    S_FIN  = 10'b0000010000,
    S_SRD0 = 10'b0000100000,
    S_SLD  = 10'b0001000000,
    S_SRD  = 10'b0010000000,
    S_SEV  = 10'b0100000000,
    S_SEND = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (mode_t'(in_mode))
            MODE_INSERT: state_nxt = S_INS;
            MODE_SEARCH, MODE_DEL_NAME, MODE_DEL_POS, MODE_PRINT, MODE_MAX:
              state_nxt = S_RD;
            MODE_SORT: state_nxt = st.few ? S_FIN : S_SRD0;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (st.ins_done) state_nxt = S_FIN;
      end
      S_RD: begin
        if (st.at_end || st.cap_hit) begin
          if (st.mode == MODE_MAX && !st.pass2) begin
            cmd.pass2 = 1'b1;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        if (st.out_free) begin
          cmd.eval  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SRD0: state_nxt = S_SLD;
      S_SLD: begin
        cmd.srt_ld = 1'b1;
        state_nxt  = S_SRD;
      end
      S_SRD: state_nxt = S_SEV;
      S_SEV: begin
        cmd.srt_ev = 1'b1;
        state_nxt  = st.srt_last ? S_SEND : S_SRD;
      end
      S_SEND: begin
        cmd.srt_end = 1'b1;
        state_nxt   = st.srt_pass_last ? S_FIN : S_SRD0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> src/rst_tbl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rst_tbl_dp
// Record store, valid marks, scan counters, match logic and result register.
// ----------------------------------------------------------------------------
module rst_tbl_dp #(
  parameter int SLOTS = rst_tbl_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_mode,
  input  rst_tbl_pkg::rec_t  in_rec,
  input  rst_tbl_pkg::cmd_t  cmd,
  output rst_tbl_pkg::stat_t st,
  output logic               out_valid,
  input  logic               out_ready,
  output rst_tbl_pkg::out_t  out_data
);
  import rst_tbl_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(RESULT_CAP + 1);

  mode_t            mode_r;
  rec_t             req_r;
  logic [CW-1:0]    used_r, idx_r, pass_r, dst_r;
  logic [15:0]      max_r;
  logic             pass2_r, hit_r, full_r;
  logic [NW-1:0]    cnt_r;
  logic             pend_v_r, carry_v_r;
  rec_t             pend_r, carry_r;
  logic [CW-1:0]    pend_slot_r;
  logic [SLOTS-1:0] valid_r;
  out_t             out_r;
  logic             out_valid_r;

  logic             we;
  logic [IW-1:0]    waddr;
  rec_t             wdata;
  logic [$bits(rec_t)-1:0] rdata;
  rec_t             rd;
  logic             cur_v, lmatch, dmatch, list_eval, swap, push;
  logic [CW-1:0]    idx_m1;
  out_t             push_data;

  rst_tbl_ram #(.WIDTH($bits(rec_t)), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[IW-1:0]),
    .rdata (rdata)
  );

  assign rd     = rec_t'(rdata);
  assign cur_v  = valid_r[idx_r[IW-1:0]];
  assign idx_m1 = idx_r - 1'b1;
  assign swap   = carry_r.health < rd.health;

  always_comb begin
    case (mode_r)
      MODE_SEARCH: lmatch = cur_v && (rd.key == req_r.key);
      MODE_PRINT:  lmatch = cur_v;
      MODE_MAX:    lmatch = cur_v && (rd.health == max_r);
      default:     lmatch = 1'b0;
    endcase
    case (mode_r)
      MODE_DEL_NAME: dmatch = cur_v && (rd.key == req_r.key);
      MODE_DEL_POS:  dmatch = cur_v && (rd.position == req_r.position);
      default:       dmatch = 1'b0;
    endcase
    list_eval = (mode_r == MODE_SEARCH) || (mode_r == MODE_PRINT) ||
                ((mode_r == MODE_MAX) && pass2_r);
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_m1[IW-1:0];
    wdata = carry_r;
    if (cmd.finish && mode_r == MODE_INSERT && !full_r) begin
      we    = 1'b1;
      waddr = dst_r[IW-1:0];
      wdata = req_r;
    end else if (cmd.srt_ev) begin
      we    = 1'b1;
      wdata = swap ? rd : carry_r;
    end else if (cmd.srt_end) begin
      we    = 1'b1;
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (cmd.eval && list_eval && lmatch && pend_v_r) begin
      push           = 1'b1;
      push_data.last = 1'b0;
      push_data.status = ST_RECORD;
      push_data.slot = 5'(pend_slot_r);
      push_data.rec  = pend_r;
    end else if (cmd.finish) begin
      push             = 1'b1;
      push_data.last   = 1'b1;
      push_data.status = ST_DONE;
      case (mode_r)
        MODE_INSERT: begin
          if (full_r) begin
            push_data.status = ST_FULL;
          end else begin
            push_data.slot = 5'(dst_r);
            push_data.rec  = req_r;
          end
        end
        MODE_SEARCH, MODE_PRINT, MODE_MAX: begin
          if (pend_v_r) begin
            push_data.status = ST_RECORD;
            push_data.slot   = 5'(pend_slot_r);
            push_data.rec    = pend_r;
          end else begin
            push_data.status = (mode_r == MODE_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
          end
        end
        MODE_DEL_NAME, MODE_DEL_POS:
          push_data.status = hit_r ? ST_DONE : ST_NOT_FOUND;
        default: push_data.status = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      idx_r       <= '0;
      pass_r      <= '0;
      pass2_r     <= 1'b0;
      hit_r       <= 1'b0;
      cnt_r       <= '0;
      mode_r      <= MODE_INSERT;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        mode_r   <= mode_t'(in_mode);
        idx_r    <= '0;
        pass_r   <= '0;
        pass2_r  <= 1'b0;
        hit_r    <= 1'b0;
        cnt_r    <= '0;
        pend_v_r <= 1'b0;
      end
      if (cmd.ins_step && !st.ins_done) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.pass2) begin
        pass2_r <= 1'b1;
        idx_r   <= '0;
      end
      if (cmd.eval) begin
        idx_r <= idx_r + 1'b1;
        if (dmatch) begin
          valid_r[idx_r[IW-1:0]] <= 1'b0;
          hit_r <= 1'b1;
        end
        if (list_eval && lmatch) begin
          pend_v_r <= 1'b1;
          cnt_r    <= cnt_r + 1'b1;
        end
      end
      if (cmd.finish && mode_r == MODE_INSERT && !full_r) begin
        valid_r[dst_r[IW-1:0]] <= 1'b1;
        if (dst_r == used_r) used_r <= used_r + 1'b1;
      end
      if (cmd.srt_ld) begin
        idx_r <= CW'(1);
      end
      if (cmd.srt_ev) begin
        valid_r[idx_m1[IW-1:0]] <= swap ? cur_v : carry_v_r;
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.srt_end) begin
        valid_r[idx_m1[IW-1:0]] <= carry_v_r;
        idx_r  <= '0;
        pass_r <= pass_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_rec;
      max_r <= '0;
    end
    if (push) begin
      out_r <= push_data;
    end
    if (cmd.ins_step && st.ins_done) begin
      dst_r  <= idx_r;
      full_r <= st.at_end && (used_r == CW'(SLOTS));
    end
    if (cmd.eval && mode_r == MODE_MAX && !pass2_r && cur_v && rd.health > max_r) begin
      max_r <= rd.health;
    end
    if (cmd.eval && list_eval && lmatch) begin
      pend_r      <= rd;
      pend_slot_r <= idx_r;
    end
    if (cmd.srt_ld || (cmd.srt_ev && !swap)) begin
      carry_r   <= rd;
      carry_v_r <= cur_v;
    end
  end

  always_comb begin
    st.mode          = mode_r;
    st.at_end        = idx_r == used_r;
    st.cap_hit       = cnt_r == NW'(RESULT_CAP);
    st.ins_done      = (idx_r == used_r) || !cur_v;
    st.out_free      = !out_valid_r || out_ready;
    st.srt_last      = (idx_r + 1'b1) == used_r;
    st.srt_pass_last = (pass_r + CW'(2)) == used_r;
    st.few           = used_r < CW'(2);
    st.pass2         = pass2_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(SLOTS)) else $error("used count beyond table depth");
  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(RESULT_CAP)) else $error("listing count beyond cap");
  a_srt_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srt_ev |-> idx_r != '0) else $error("sort step at slot zero");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || out_ready)) else $error("result overwritten");
`endif

endmodule

>>> src/record_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_slot_table
// Table of name-keyed records with insert, search, delete, listing and sort.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    mode, name key, stats, position
// out      output     out_valid/out_ready  last, status, slot, record
//
// A scan reads each used slot from the registered RAM, then evaluates it.
// Insert: scans up to the first free slot; find max: two scans; sort:
// (used-1) passes of (used-1) compares.
// Reset clears valid marks and used count at once; no clearing pass.
// A stalled result holds the scan until the result register frees.
// ----------------------------------------------------------------------------
module record_slot_table #(
  parameter int SLOTS = rst_tbl_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_name_key,
  input  logic [15:0] in_health,
  input  logic [15:0] in_mana,
  input  logic [15:0] in_move_speed,
  input  logic [9:0]  in_reach,
  input  logic [2:0]  in_position_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [4:0]  out_slot,
  output logic [63:0] out_name_key,
  output logic [15:0] out_health,
  output logic [15:0] out_mana,
  output logic [15:0] out_speed,
  output logic [9:0]  out_reach,
  output logic [2:0]  out_position
);
  import rst_tbl_pkg::*;

  cmd_t  cmd;
  stat_t st;
  rec_t  in_rec;
  out_t  out_data;

  assign in_rec.key      = in_name_key;
  assign in_rec.health   = in_health;
  assign in_rec.mana     = in_mana;
  assign in_rec.speed    = in_move_speed;
  assign in_rec.reach    = in_reach;
  assign in_rec.position = in_position_code;

  rst_tbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .st       (st),
    .cmd      (cmd)
  );

  rst_tbl_dp #(.SLOTS(SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mode   (in_mode),
    .in_rec    (in_rec),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_last     = out_data.last;
  assign out_status   = out_data.status;
  assign out_slot     = out_data.slot;
  assign out_name_key = out_data.rec.key;
  assign out_health   = out_data.rec.health;
  assign out_mana     = out_data.rec.mana;
  assign out_speed    = out_data.rec.speed;
  assign out_reach    = out_data.rec.reach;
  assign out_position = out_data.rec.position;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the record slot table against a behavioral model of the table:
// directed commands for each mode, a full-table case, sort and max cases,
// then random command streams with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import rst_tbl_pkg::*;

  localparam int NSLOT = 32;
  localparam int CYCLE_LIMIT = 10000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [63:0] in_name_key = '0;
  logic [15:0] in_health = '0;
  logic [15:0] in_mana = '0;
  logic [15:0] in_move_speed = '0;
  logic [9:0]  in_reach = '0;
  logic [2:0]  in_position_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_last;
  logic [2:0]  out_status;
  logic [4:0]  out_slot;
  logic [63:0] out_name_key;
  logic [15:0] out_health;
  logic [15:0] out_mana;
  logic [15:0] out_speed;
  logic [9:0]  out_reach;
  logic [2:0]  out_position;

  record_slot_table #(.SLOTS(NSLOT)) i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rec_t      tbl_rec [NSLOT];
  bit        tbl_vld [NSLOT];
  int        tbl_used;
  out_t      expected_q [$];
  int        errors;
  longint    cycles;
  int        stall_left;
  bit        stall_en = 1'b1;
  logic [63:0] known_keys [8];

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic queue_result(out_t o);
    expected_q.insert(expected_q.size(), o);
  endtask

  function automatic out_t mk(bit lst, status_t st, int idx);
    out_t o;
    o = '0;
    o.last = lst;
    o.status = st;
    if (idx >= 0) begin
      o.slot = idx[4:0];
      o.rec = tbl_rec[idx];
    end
    return o;
  endfunction

  function automatic bit listed(int i, mode_t m, logic [63:0] key, logic [15:0] mx);
    if (!tbl_vld[i]) return 0;
    if (m == MODE_SEARCH) return tbl_rec[i].key == key;
    if (m == MODE_MAX) return tbl_rec[i].health == mx;
    return 1;
  endfunction

  task automatic list_records(mode_t m, logic [63:0] key, logic [15:0] mx, status_t empty);
    int total;
    int k;
    total = 0;
    k = 0;
    for (int i = 0; i < tbl_used; i++) if (listed(i, m, key, mx)) total++;
    if (total == 0) begin
      queue_result(mk(1, empty, -1));
      return;
    end
    if (total > RESULT_CAP) total = RESULT_CAP;
    for (int i = 0; i < tbl_used && k < total; i++)
      if (listed(i, m, key, mx)) begin
        queue_result(mk(k + 1 == total, ST_RECORD, i));
        k++;
      end
  endtask

  task automatic apply_command(logic [2:0] m, rec_t r);
    int dst;
    bit hit;
    logic [15:0] mx;
    rec_t tr;
    bit tv;
    case (m)
      MODE_INSERT: begin
        dst = tbl_used;
        for (int i = 0; i < tbl_used; i++) if (!tbl_vld[i]) begin dst = i; break; end
        if (dst >= NSLOT) queue_result(mk(1, ST_FULL, -1));
        else begin
          if (dst == tbl_used) tbl_used++;
          tbl_rec[dst] = r;
          tbl_vld[dst] = 1;
          queue_result(mk(1, ST_DONE, dst));
        end
      end
      MODE_SEARCH: list_records(MODE_SEARCH, r.key, 0, ST_NOT_FOUND);
      MODE_DEL_NAME, MODE_DEL_POS: begin
        hit = 0;
        for (int i = 0; i < tbl_used; i++)
          if (tbl_vld[i] && (m == MODE_DEL_NAME ? tbl_rec[i].key == r.key
                                                : tbl_rec[i].position == r.position)) begin
            tbl_vld[i] = 0;
            hit = 1;
          end
        queue_result(mk(1, hit ? ST_DONE : ST_NOT_FOUND, -1));
      end
      MODE_PRINT: list_records(MODE_PRINT, 0, 0, ST_EMPTY);
      MODE_MAX: begin
        mx = 0;
        for (int i = 0; i < tbl_used; i++)
          if (tbl_vld[i] && tbl_rec[i].health > mx) mx = tbl_rec[i].health;
        list_records(MODE_MAX, 0, mx, ST_EMPTY);
      end
      MODE_SORT: begin
        for (int j = 1; j < tbl_used; j++)
          for (int i = 0; i + 1 < tbl_used; i++)
            if (tbl_rec[i].health < tbl_rec[i + 1].health) begin
              tr = tbl_rec[i]; tbl_rec[i] = tbl_rec[i + 1]; tbl_rec[i + 1] = tr;
              tv = tbl_vld[i]; tbl_vld[i] = tbl_vld[i + 1]; tbl_vld[i + 1] = tv;
            end
        queue_result(mk(1, ST_DONE, -1));
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(logic [2:0] m, rec_t r, bit idle_ok = 1);
    int g;
    g = idle_ok ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    apply_command(m, r);
    in_mode <= m;
    in_name_key <= r.key;
    in_health <= r.health;
    in_mana <= r.mana;
    in_move_speed <= r.speed;
    in_reach <= r.reach;
    in_position_code <= r.position;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic rec_t rand_rec();
    rec_t r;
    r.key = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : known_keys[$urandom_range(0, 7)];
    r.health = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6) * 100);
    r.mana = 16'($urandom);
    r.speed = 16'($urandom);
    r.reach = 10'($urandom);
    r.position = 3'($urandom);
    return r;
  endfunction

  function automatic rec_t rec_of(logic [63:0] k, logic [15:0] h, logic [2:0] p);
    rec_t r;
    r = '{key: k, health: h, mana: ~h, speed: h ^ 16'h5a5a, reach: h[9:0], position: p};
    return r;
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // output side
  always @(posedge clk) begin
    out_t got;
    out_t exp_o;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{last: out_last, status: status_t'(out_status), slot: out_slot,
              rec: '{out_name_key, out_health, out_mana, out_speed, out_reach, out_position}};
      if (expected_q.size() == 0) report("unexpected result");
      else begin
        exp_o = expected_q.pop_front();
        if (got.last !== exp_o.last) report($sformatf("last %b exp %b", got.last, exp_o.last));
        if (got.status !== exp_o.status)
          report($sformatf("status %0d exp %0d", got.status, exp_o.status));
        if (got.slot !== exp_o.slot) report($sformatf("slot %0d exp %0d", got.slot, exp_o.slot));
        if (got.rec !== exp_o.rec) report($sformatf("record %h exp %h", got.rec, exp_o.rec));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 9) < 3) begin
      stall_left = gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_empty_table();
    send_request(MODE_PRINT, '0);
    send_request(MODE_MAX, '0);
    send_request(MODE_SEARCH, rec_of(64'h1, 0, 0));
    send_request(MODE_DEL_NAME, rec_of(64'h1, 0, 0));
    send_request(MODE_DEL_POS, rec_of(0, 0, 3'd7));
    send_request(MODE_SORT, '0);
    send_request(3'd7, '0);
  endtask

  task automatic test_basic_modes();
    send_request(MODE_INSERT, '{64'hffff_ffff_ffff_ffff, 16'hffff, 16'hffff, 16'hffff, 10'h3ff, 3'd7});
    send_request(MODE_INSERT, '0);
    send_request(MODE_INSERT, rec_of(64'h4b4e_4947_4854, 16'd500, 3'd2));
    send_request(MODE_INSERT, rec_of(64'h4b4e_4947_4854, 16'hffff, 3'd2));
    send_request(MODE_SEARCH, rec_of(64'h4b4e_4947_4854, 0, 0));
    send_request(MODE_MAX, '0);
    send_request(MODE_PRINT, '0);
    send_request(MODE_DEL_NAME, rec_of(64'h4b4e_4947_4854, 0, 0));
    send_request(MODE_INSERT, rec_of(64'h77, 16'd9, 3'd1));
    send_request(MODE_SORT, '0);
    send_request(MODE_DEL_POS, rec_of(0, 0, 3'd7));
    send_request(MODE_PRINT, '0);
    wait_drain();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NSLOT + 2; i++)
      send_request(MODE_INSERT, rec_of(64'(i % 5), 16'($urandom_range(0, 3) * 7), 3'(i)), 0);
    send_request(MODE_PRINT, '0);
    send_request(MODE_MAX, '0);
    send_request(MODE_SORT, '0);
    send_request(MODE_PRINT, '0);
    send_request(MODE_DEL_POS, rec_of(0, 0, 3'd3));
    send_request(MODE_INSERT, rec_of(64'h99, 16'd1, 3'd0));
    wait_drain();
  endtask

  task automatic test_random_mix();
    int pick;
    logic [2:0] m;
    for (int n = 0; n < 300; n++) begin
      stall_en = (n / 60) % 2 == 0;
      pick = $urandom_range(0, 99);
      if (pick < 40) m = MODE_INSERT;
      else if (pick < 52) m = MODE_SEARCH;
      else if (pick < 62) m = MODE_DEL_NAME;
      else if (pick < 68) m = MODE_DEL_POS;
      else if (pick < 78) m = MODE_PRINT;
      else if (pick < 88) m = MODE_MAX;
      else if (pick < 96) m = MODE_SORT;
      else m = 3'd7;
      send_request(m, rand_rec(), stall_en);
    end
    stall_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) known_keys[i] = {$urandom, $urandom};
    tbl_used = 0;
    foreach (tbl_vld[i]) tbl_vld[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_basic_modes();
    test_full_table();
    test_random_mix();
    wait_drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
